// ===== sv/mqsb_pkg.sv =====
// ----------------------------------------------------------------------------
// mqsb_pkg: shared types and constants
// Request and response words, status and mode codes, default sizes for the
// multi-queue shared buffer.
// ----------------------------------------------------------------------------
package mqsb_pkg;

	localparam int NUM_SLOTS_DEF  = 16;
	localparam int NUM_QUEUES_DEF = 4;
	localparam int QUEUE_ID_W     = 2;
	localparam int DATA_W         = 32;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic                     mode;
		logic [QUEUE_ID_W-1:0]    queue_id;
		logic signed [DATA_W-1:0] data_in;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] data_out;
	} rsp_t;

endpackage

// ===== sv/mqsb_ram.sv =====
// ----------------------------------------------------------------------------
// mqsb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mqsb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/multi_queue_shared_buffer.sv =====
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer: linked-list queues in one shared slot store
// NUM_QUEUES FIFO queues share NUM_SLOTS data slots through a free list and
// per-slot link words held in RAM.
//
// Request channel (req_valid/req_stall/req): one word per request, either an
// enqueue of data_in to queue_id or a dequeue from queue_id. Response channel
// (rsp_valid/rsp_stall/rsp): exactly one word per request, in order, with
// status ok, full or empty, and the data on a successful dequeue.
// A full or empty response is loaded from state LOOK, an ok response from
// LINK (enqueue) or FETCH (dequeue), which follow LOOK. The next request is
// taken the cycle after the response is loaded; no new request is taken
// while one is in progress. The link words sit in a RAM with registered
// reads, one write port and one read port.
// After reset a clearing pass chains the free list and empties all queues;
// requests stall meanwhile.
// A stalled response holds in the output register; the block still accepts
// one new request and finishes its work up to the point of delivery, then
// waits until the output register frees.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer import mqsb_pkg::*; #(
	parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
	parameter int NUM_QUEUES = NUM_QUEUES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int SW     = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
	localparam int LW     = $clog2(NUM_SLOTS + 1);
	localparam int QW     = NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1;
	localparam int QXW    = QW > QUEUE_ID_W ? QW : QUEUE_ID_W;
	localparam int INIT_N = NUM_SLOTS > NUM_QUEUES ? NUM_SLOTS : NUM_QUEUES;
	localparam int CW     = $clog2(INIT_N);
	localparam logic [LW-1:0] LINK_NULL = LW'(NUM_SLOTS);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_LOOK,
		S_LINK,
		S_FETCH
	} state_t;

	function automatic logic is_slot(input logic [LW-1:0] p);
		return p < LINK_NULL;
	endfunction

	function automatic logic [LW-1:0] norm_link(input logic [LW-1:0] p);
		return (p < LINK_NULL) ? p : LINK_NULL;
	endfunction

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	req_t            req_q;
	logic [SW-1:0]   slot_q;
	logic [LW-1:0]   free_head_q;
	rsp_t            rsp_q;
	logic            rsp_valid_q;

	logic [LW-1:0]     head_rd, tail_rd, link_rd;
	logic [DATA_W-1:0] data_rd;

	logic              hq_we, tq_we, lk_we, dt_we, lk_re, dt_re, hq_re;
	logic [QW-1:0]     hq_waddr, tq_waddr, hq_raddr;
	logic [LW-1:0]     hq_wdata, tq_wdata, lk_wdata;
	logic [SW-1:0]     lk_waddr, lk_raddr, dt_waddr, dt_raddr;
	logic [DATA_W-1:0] dt_wdata;

	logic [QXW-1:0] q_in, q_cur;
	logic           q_ok, accept, out_free, enq_full, deq_empty, head_is_slot;
	logic           load_rsp;

	assign req_stall    = (state_q != S_IDLE);
	assign accept       = req_valid && (state_q == S_IDLE);
	assign out_free     = !rsp_valid_q || !rsp_stall;
	assign q_in         = QXW'(req.queue_id);
	assign q_cur        = QXW'(req_q.queue_id);
	assign q_ok         = 32'(req_q.queue_id) < 32'(NUM_QUEUES);
	assign head_is_slot = is_slot(head_rd);
	assign enq_full     = !q_ok || !is_slot(free_head_q);
	assign deq_empty    = !q_ok || !head_is_slot;
	assign load_rsp     = out_free && ((state_q == S_LOOK &&
		((req_q.mode == MODE_ENQ) ? enq_full : deq_empty)) ||
		state_q == S_LINK || state_q == S_FETCH);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		hq_re    = accept;
		hq_raddr = q_in[QW-1:0];
		hq_we    = 1'b0;
		hq_waddr = q_cur[QW-1:0];
		hq_wdata = free_head_q;
		tq_we    = 1'b0;
		tq_waddr = q_cur[QW-1:0];
		tq_wdata = free_head_q;
		lk_we    = 1'b0;
		lk_waddr = slot_q;
		lk_wdata = LINK_NULL;
		lk_re    = 1'b0;
		lk_raddr = free_head_q[SW-1:0];
		dt_we    = 1'b0;
		dt_waddr = free_head_q[SW-1:0];
		dt_wdata = req_q.data_in;
		dt_re    = 1'b0;
		dt_raddr = head_rd[SW-1:0];
		case (state_q)
			S_INIT: begin
				lk_we    = 32'(cnt_q) < 32'(NUM_SLOTS);
				lk_waddr = cnt_q[SW-1:0];
				lk_wdata = LW'(cnt_q) + LW'(1);
				hq_we    = 32'(cnt_q) < 32'(NUM_QUEUES);
				hq_waddr = cnt_q[QW-1:0];
				hq_wdata = LINK_NULL;
			end
			S_IDLE: begin
				lk_re = accept;
			end
			S_LOOK: begin
				if (req_q.mode == MODE_ENQ) begin
					if (!enq_full) begin
						hq_we    = !head_is_slot;
						tq_we    = 1'b1;
						lk_we    = head_is_slot && is_slot(tail_rd);
						lk_waddr = tail_rd[SW-1:0];
						lk_wdata = free_head_q;
						dt_we    = 1'b1;
					end
				end else begin
					if (!deq_empty) begin
						lk_re    = 1'b1;
						lk_raddr = head_rd[SW-1:0];
						dt_re    = 1'b1;
					end
				end
			end
			S_LINK: begin
				lk_we = out_free;
			end
			S_FETCH: begin
				hq_we    = out_free;
				hq_wdata = norm_link(link_rd);
				lk_we    = out_free;
				lk_wdata = free_head_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cnt_q       <= '0;
			free_head_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(INIT_N - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (req_q.mode == MODE_ENQ) begin
						if (enq_full) begin
							if (out_free) begin
								rsp_q   <= '{status: ST_FULL, data_out: '0};
								state_q <= S_IDLE;
							end
						end else begin
							free_head_q <= norm_link(link_rd);
							slot_q      <= free_head_q[SW-1:0];
							state_q     <= S_LINK;
						end
					end else begin
						if (deq_empty) begin
							if (out_free) begin
								rsp_q   <= '{status: ST_EMPTY, data_out: '0};
								state_q <= S_IDLE;
							end
						end else begin
							slot_q  <= head_rd[SW-1:0];
							state_q <= S_FETCH;
						end
					end
				end
				S_LINK: begin
					if (out_free) begin
						rsp_q   <= '{status: ST_OK, data_out: '0};
						state_q <= S_IDLE;
					end
				end
				S_FETCH: begin
					if (out_free) begin
						free_head_q <= LW'(slot_q);
						rsp_q       <= '{status: ST_OK, data_out: data_rd};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	mqsb_ram #(.WIDTH(DATA_W), .DEPTH(NUM_SLOTS)) u_data (
		.clk   (clk),
		.we    (dt_we),
		.waddr (dt_waddr),
		.wdata (dt_wdata),
		.re    (dt_re),
		.raddr (dt_raddr),
		.rdata (data_rd)
	);

	mqsb_ram #(.WIDTH(LW), .DEPTH(NUM_SLOTS)) u_link (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.re    (lk_re),
		.raddr (lk_raddr),
		.rdata (link_rd)
	);

	mqsb_ram #(.WIDTH(LW), .DEPTH(NUM_QUEUES)) u_head (
		.clk   (clk),
		.we    (hq_we),
		.waddr (hq_waddr),
		.wdata (hq_wdata),
		.re    (hq_re),
		.raddr (hq_raddr),
		.rdata (head_rd)
	);

	mqsb_ram #(.WIDTH(LW), .DEPTH(NUM_QUEUES)) u_tail (
		.clk   (clk),
		.we    (tq_we),
		.waddr (tq_waddr),
		.wdata (tq_wdata),
		.re    (hq_re),
		.raddr (hq_raddr),
		.rdata (tail_rd)
	);

	a_free_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= LINK_NULL)
		else $error("free list head out of range");

	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) |-> (req_stall && !rsp_valid))
		else $error("channel active during clearing pass");

	a_slot_not_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOK && req_q.mode == MODE_ENQ && !enq_full && head_is_slot)
		|-> (tail_rd != free_head_q))
		else $error("free slot is also a queue tail");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOK && req_q.mode == MODE_DEQ && deq_empty && out_free)
		|=> (rsp_valid && rsp.status == ST_EMPTY))
		else $error("empty dequeue without empty status");

endmodule

// ===== verif/mqsb_queue_checker.sv =====
// ----------------------------------------------------------------------------
// mqsb_queue_checker: response checker for the multi-queue shared buffer
// Watches both channels, keeps its own copy of the slot store, link words,
// queue heads and tails and the free list, predicts the response word of
// every accepted request and compares each accepted response with the oldest
// prediction.
// ----------------------------------------------------------------------------
module mqsb_queue_checker import mqsb_pkg::*; #(
	parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
	parameter int NUM_QUEUES = NUM_QUEUES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   errors,
	output int   owed
);

	localparam int LINK_W = $clog2(NUM_SLOTS + 1);
	localparam int SLOT_W = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
	localparam int QSEL_W = NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1;
	localparam int REPORT_MAX = 10;

	typedef logic [LINK_W-1:0] link_t;

	localparam link_t LINK_NULL = link_t'(NUM_SLOTS);

	logic signed [DATA_W-1:0] slot_word [NUM_SLOTS];
	link_t                    slot_next [NUM_SLOTS];
	link_t                    head      [NUM_QUEUES];
	link_t                    tail      [NUM_QUEUES];
	link_t                    free_head;

	rsp_t owed_rsp [$];
	int   n_bad;
	int   n_rsp;

	function automatic rsp_t apply_request(input req_t r);
		rsp_t              res;
		link_t             slot;
		logic [SLOT_W-1:0] s;
		logic [QSEL_W-1:0] qs;
		int                q;
		res = '0;
		res.status = ST_OK;
		q = int'(r.queue_id);
		qs = QSEL_W'(r.queue_id);
		if (r.mode == MODE_ENQ) begin
			if (q >= NUM_QUEUES || free_head >= NUM_SLOTS) begin
				res.status = ST_FULL;
			end else begin
				slot = free_head;
				s = slot[SLOT_W-1:0];
				free_head = (slot_next[s] < NUM_SLOTS) ? slot_next[s] : LINK_NULL;
				if (head[qs] >= NUM_SLOTS) begin
					head[qs] = slot;
				end else if (tail[qs] < NUM_SLOTS) begin
					slot_next[tail[qs][SLOT_W-1:0]] = slot;
				end
				slot_next[s] = LINK_NULL;
				tail[qs] = slot;
				slot_word[s] = r.data_in;
			end
		end else begin
			if (q >= NUM_QUEUES || head[qs] >= NUM_SLOTS) begin
				res.status = ST_EMPTY;
			end else begin
				slot = head[qs];
				s = slot[SLOT_W-1:0];
				head[qs] = (slot_next[s] < NUM_SLOTS) ? slot_next[s] : LINK_NULL;
				slot_next[s] = free_head;
				free_head = slot;
				res.data_out = slot_word[s];
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_word[SLOT_W'(i)] = '0;
				slot_next[SLOT_W'(i)] = (i == NUM_SLOTS - 1) ? LINK_NULL : link_t'(i + 1);
			end
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head[QSEL_W'(i)] = LINK_NULL;
				tail[QSEL_W'(i)] = LINK_NULL;
			end
			free_head = '0;
			owed_rsp.delete();
			n_bad = 0;
			n_rsp = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_rsp.size() == 0) begin
					n_bad++;
					if (n_bad <= REPORT_MAX)
						$display("rsp %0d: word with none outstanding, status %0d data_out %h",
							n_rsp, rsp.status, rsp.data_out);
				end else begin
					want = owed_rsp.pop_front();
					if (rsp.status !== want.status || rsp.data_out !== want.data_out) begin
						n_bad++;
						if (n_bad <= REPORT_MAX)
							$display("rsp %0d: status exp %0d got %0d, data_out exp %h got %h",
								n_rsp, want.status, rsp.status, want.data_out, rsp.data_out);
					end
				end
				n_rsp++;
			end
			if (req_valid && !req_stall)
				owed_rsp.push_back(apply_request(req));
		end
		errors <= n_bad;
		owed   <= owed_rsp.size();
	end

endmodule

// ===== verif/tb_multi_queue_shared_buffer.sv =====
// ----------------------------------------------------------------------------
// tb_multi_queue_shared_buffer: regression bench for the shared-buffer queues
// Drives directed requests (empty dequeue, data extremes, stale tail, store
// full) and then bursts of random enqueues and dequeues with fill and drain
// phases, random sender gaps and receiver stalls, one long response hold-off
// and a full drain mid-run. The checker predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_multi_queue_shared_buffer;
	import mqsb_pkg::*;

	localparam int RAND_ITEMS     = 650;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 12;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	int   errors;
	int   owed;
	bit   holdoff_req = 1'b0;

	multi_queue_shared_buffer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	mqsb_queue_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.errors    (errors),
		.owed      (owed)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic req_t make_req(input logic mode, input logic [QUEUE_ID_W-1:0] qid,
			input logic signed [DATA_W-1:0] word);
		req_t r;
		r.mode     = mode;
		r.queue_id = qid;
		r.data_in  = word;
		return r;
	endfunction

	task automatic offer_word(input req_t r);
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic idle_sender(input int unsigned cycles);
		req_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (owed != 0) @(posedge clk);
	endtask

	// receiver: random stall phases, one long hold-off on request
	initial begin
		int unsigned pct;
		int unsigned span;
		rsp_stall = 1'b0;
		@(posedge clk);
		forever begin
			if (holdoff_req) begin
				rsp_stall <= 1'b1;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
				holdoff_req = 1'b0;
			end else begin
				case ($urandom_range(3))
					0: pct = 0;
					1: pct = 20;
					2: pct = 50;
					default: pct = 85;
				endcase
				span = $urandom_range(10, 150);
				for (int c = 0; c < span && !holdoff_req; c++) begin
					rsp_stall <= ($urandom_range(99) < pct);
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("multi_queue_shared_buffer regression: fail");
		$finish;
	end

	initial begin
		logic signed [DATA_W-1:0] word;
		logic [QUEUE_ID_W-1:0]    qid;
		logic                     mode;
		int unsigned n;
		int unsigned burst;
		int unsigned gap;
		int unsigned enq_pct;
		int unsigned focus_q;
		bit          one_queue;
		bit          held;
		bit          paused;

		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		held      = 1'b0;
		paused    = 1'b0;
		enq_pct   = 50;
		focus_q   = 0;
		one_queue = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		offer_word(make_req(MODE_DEQ, 2'd0, '0));
		offer_word(make_req(MODE_ENQ, 2'd0, 32'sh7FFF_FFFF));
		offer_word(make_req(MODE_ENQ, 2'd0, 32'sh8000_0000));
		offer_word(make_req(MODE_DEQ, 2'd0, '1));
		offer_word(make_req(MODE_DEQ, 2'd0, '0));
		offer_word(make_req(MODE_DEQ, 2'd0, '0));
		offer_word(make_req(MODE_ENQ, 2'd0, '1));
		offer_word(make_req(MODE_DEQ, 2'd0, '0));
		for (int i = 0; i < NUM_SLOTS_DEF; i++)
			offer_word(make_req(MODE_ENQ, QUEUE_ID_W'(3 - i % 4),
				(i % 2) ? ~(32'sd1 << i) : (32'sd1 << (31 - i))));
		offer_word(make_req(MODE_ENQ, 2'd1, 32'sh1234_5678));

		n = 0;
		while (n < RAND_ITEMS) begin
			if (n >= 150 && !held) begin
				holdoff_req = 1'b1;
				held = 1'b1;
			end
			if (n >= 400 && !paused) begin
				wait_drained();
				paused = 1'b1;
			end
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < RAND_ITEMS; k++) begin
				if (n % 40 == 0) begin
					case ($urandom_range(2))
						0: enq_pct = 85;
						1: enq_pct = 50;
						default: enq_pct = 20;
					endcase
					one_queue = ($urandom_range(3) == 0);
					focus_q = $urandom_range(3);
				end
				case ($urandom_range(15))
					0: word = 32'sh7FFF_FFFF;
					1: word = 32'sh8000_0000;
					2: word = '0;
					3: word = '1;
					default: word = $urandom;
				endcase
				mode = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
				qid = one_queue ? QUEUE_ID_W'(focus_q) : QUEUE_ID_W'($urandom_range(3));
				offer_word(make_req(mode, qid, word));
				n++;
			end
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0)
				idle_sender(gap);
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && owed == 0)
			$display("multi_queue_shared_buffer regression: pass");
		else
			$display("multi_queue_shared_buffer regression: fail");
		$finish;
	end

endmodule
